### sv/cgv_pkg.sv
// Shared types, constants and helpers for the chained-keystream cipher.
package cgv_pkg;

    localparam int KEY_MAX  = 16;
    localparam int POS_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CNT_W    = POS_W + 1;
    localparam int LEN_W    = (CNT_W > 5) ? CNT_W : 5;
    localparam int LETTER_W = 5;
    localparam int SLOT_W   = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [LETTER_W-1:0] ALPHA = LETTER_W'(26);

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    typedef enum logic [0:0] {
        REG_KEY_LENGTH   = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [4:0] key_length;
        logic       decrypt_mode;
    } t_cfg;

    typedef struct packed {
        logic                kind;
        logic [LETTER_W-1:0] letter;
        logic [SLOT_W-1:0]   key_slot;
        logic                restart;
    } t_item;

    // Reduce a value below 2*26 into 0..25.
    function automatic logic [LETTER_W-1:0] mod26(input logic [LETTER_W:0] v);
        logic [LETTER_W:0] d;
        d = v - {1'b0, ALPHA};
        return (v < {1'b0, ALPHA}) ? v[LETTER_W-1:0] : d[LETTER_W-1:0];
    endfunction

endpackage

### sv/cgv_core.sv
// Key store, plaintext history and the combinational keystream recurrence.
module cgv_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  cgv_pkg::t_cfg                 i_cfg,
    input  cgv_pkg::t_item                i_item,
    output logic [cgv_pkg::LETTER_W-1:0]  o_letter_out
);

    logic [cgv_pkg::LETTER_W-1:0] r_key_store [cgv_pkg::KEY_MAX];
    logic [cgv_pkg::LETTER_W-1:0] r_hist      [cgv_pkg::KEY_MAX];
    logic [cgv_pkg::LETTER_W-1:0] r_prev_ks;
    logic [cgv_pkg::POS_W-1:0]    r_pos;
    logic                         r_past;

    logic [cgv_pkg::LETTER_W-1:0] n_prev_ks;
    logic [cgv_pkg::POS_W-1:0]    n_pos;
    logic                         n_past;

    logic [cgv_pkg::LETTER_W-1:0] let_v;
    logic [cgv_pkg::LETTER_W-1:0] prev_v;
    logic [cgv_pkg::LETTER_W-1:0] ks;
    logic [cgv_pkg::LETTER_W-1:0] result;
    logic [cgv_pkg::LETTER_W-1:0] plain;
    logic [cgv_pkg::POS_W-1:0]    pos;
    logic                         past;
    logic [cgv_pkg::LEN_W-1:0]    len_eff;
    logic [cgv_pkg::LEN_W-1:0]    next;
    logic                         is_text;
    logic                         slot_ok;

    always_comb begin
        is_text = (i_item.kind == cgv_pkg::KIND_TEXT);
        let_v   = cgv_pkg::mod26({1'b0, i_item.letter});
        slot_ok = (32'(i_item.key_slot) < 32'(cgv_pkg::KEY_MAX));

        // restart starts the message over in the same cycle
        pos    = i_item.restart ? '0 : r_pos;
        past   = i_item.restart ? 1'b0 : r_past;
        prev_v = i_item.restart ? '0 : r_prev_ks;

        ks = past ? cgv_pkg::mod26({1'b0, r_hist[pos]} + {1'b0, prev_v})
                  : r_key_store[pos];

        if (i_cfg.decrypt_mode) begin
            result = cgv_pkg::mod26({1'b0, let_v} + {1'b0, cgv_pkg::ALPHA} - {1'b0, ks});
            plain  = result;
        end else begin
            result = cgv_pkg::mod26({1'b0, let_v} + {1'b0, ks});
            plain  = let_v;
        end

        priority if (i_cfg.key_length == '0) begin
            len_eff = cgv_pkg::LEN_W'(1);
        end else if (cgv_pkg::LEN_W'(i_cfg.key_length) > cgv_pkg::LEN_W'(cgv_pkg::KEY_MAX)) begin
            len_eff = cgv_pkg::LEN_W'(cgv_pkg::KEY_MAX);
        end else begin
            len_eff = cgv_pkg::LEN_W'(i_cfg.key_length);
        end

        next      = cgv_pkg::LEN_W'(pos) + cgv_pkg::LEN_W'(1);
        n_prev_ks = ks;
        if (next >= len_eff) begin
            n_pos  = '0;
            n_past = 1'b1;
        end else begin
            n_pos  = next[cgv_pkg::POS_W-1:0];
            n_past = past;
        end
    end

    assign o_letter_out = result;

    always_ff @(posedge i_clk) begin
        if (i_en && !is_text && slot_ok) begin
            r_key_store[cgv_pkg::POS_W'(i_item.key_slot)] <= let_v;
        end
        if (i_en && is_text) begin
            r_hist[pos] <= plain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ks <= '0;
            r_pos     <= '0;
            r_past    <= 1'b0;
        end else if (i_en && is_text) begin
            r_prev_ks <= n_prev_ks;
            r_pos     <= n_pos;
            r_past    <= n_past;
        end
    end

endmodule

### sv/chained_gamma_vigenere_cipher_unit.sv
// Chained-keystream Vigenere cipher unit: top level with handshake and APB registers.
//
// Input channel (i_valid/o_stall) carries one beat per letter. kind 0 writes
// letter into the key store at key_slot and gives no result; kind 1 is a text
// letter and gives exactly one beat on the output channel (o_valid/i_stall).
// restart marks the first text letter of a message and is ignored on key beats.
// Registers over APB: key_length at 0x0, decrypt_mode at 0x4; write them only
// while no beats are in flight. Load all key slots in use before any text.
// A text beat passes through the input register, then the result register, on its way
// to o_letter_out. Throughput: one beat per cycle while the receiver does not stall;
// the mod-26 keystream update in the core is combinational.
// Reset (synchronous, active low) clears both stages, the message position and
// the keystream; key_length returns to 1 and decrypt_mode to 0. Key store and
// history are not cleared.
// When the receiver stalls, the result register holds; the input register
// still takes beats, and o_stall rises only once a text beat is held there.
module chained_gamma_vigenere_cipher_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic [cgv_pkg::LETTER_W-1:0]  i_letter,
    input  logic [cgv_pkg::SLOT_W-1:0]    i_key_slot,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cgv_pkg::LETTER_W-1:0]  o_letter_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cgv_pkg::APB_AW-1:0]    paddr,
    input  logic [cgv_pkg::APB_DW-1:0]    pwdata,
    output logic [cgv_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    cgv_pkg::t_cfg                r_cfg;
    cgv_pkg::t_item               r_s1;
    logic                         r_s1_valid;
    logic                         r_out_valid;
    logic [cgv_pkg::LETTER_W-1:0] r_out_letter;

    cgv_pkg::t_item               in_item;
    cgv_pkg::t_reg_idx            reg_idx;
    logic [cgv_pkg::LETTER_W-1:0] core_letter;
    logic                         cfg_wr;
    logic                         out_free;
    logic                         s1_adv;
    logic                         accept_in;

    assign pready  = 1'b1;
    assign reg_idx = cgv_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            cgv_pkg::REG_KEY_LENGTH:   prdata = cgv_pkg::APB_DW'(r_cfg.key_length);
            cgv_pkg::REG_DECRYPT_MODE: prdata = cgv_pkg::APB_DW'(r_cfg.decrypt_mode);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_length   <= 5'd1;
            r_cfg.decrypt_mode <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                cgv_pkg::REG_KEY_LENGTH:   r_cfg.key_length   <= pwdata[4:0];
                cgv_pkg::REG_DECRYPT_MODE: r_cfg.decrypt_mode <= pwdata[0];
                default:                   r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        in_item.kind     = i_kind;
        in_item.letter   = i_letter;
        in_item.key_slot = i_key_slot;
        in_item.restart  = i_restart;
    end

    // key beats retire without needing the result register
    assign out_free  = !r_out_valid || !i_stall;
    assign s1_adv    = r_s1_valid && ((r_s1.kind == cgv_pkg::KIND_KEY) || out_free);
    assign o_stall   = r_s1_valid && !s1_adv;
    assign accept_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1 <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept_in) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    cgv_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (s1_adv),
        .i_cfg        (r_cfg),
        .i_item       (r_s1),
        .o_letter_out (core_letter)
    );

    always_ff @(posedge i_clk) begin
        if (s1_adv && (r_s1.kind == cgv_pkg::KIND_TEXT)) begin
            r_out_letter <= core_letter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && (r_s1.kind == cgv_pkg::KIND_TEXT)) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_letter_out = r_out_letter;

`ifndef ASSERT_OFF
    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_letter_out < cgv_pkg::ALPHA))
        else $error("result letter out of range");

    a_result_from_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid && (r_s1.kind == cgv_pkg::KIND_TEXT)))
        else $error("result beat without a text beat in the input stage");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

### tb/sv/chained_gamma_vigenere_cipher_unit_test.sv
// Self-checking testbench for the chained-keystream cipher unit.
module chained_gamma_vigenere_cipher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 6;
    localparam int PHASE_BEATS      = 38;
    localparam int LONG_HOLD_CYCLES = 40;
    localparam int SETTLE_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT   = 2000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_valid    = 1'b0;
    logic                         o_stall;
    logic                         i_kind     = cgv_pkg::KIND_KEY;
    logic [cgv_pkg::LETTER_W-1:0] i_letter   = '0;
    logic [cgv_pkg::SLOT_W-1:0]   i_key_slot = '0;
    logic                         i_restart  = 1'b0;
    logic                         o_valid;
    logic                         i_stall    = 1'b0;
    logic [cgv_pkg::LETTER_W-1:0] o_letter_out;
    logic                         psel       = 1'b0;
    logic                         penable    = 1'b0;
    logic                         pwrite     = 1'b0;
    logic [cgv_pkg::APB_AW-1:0]   paddr      = '0;
    logic [cgv_pkg::APB_DW-1:0]   pwdata     = '0;
    logic [cgv_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    chained_gamma_vigenere_cipher_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_letter     (i_letter),
        .i_key_slot   (i_key_slot),
        .i_restart    (i_restart),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_letter_out (o_letter_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // stimulus and expected output
    cgv_pkg::t_item               beat_queue[$];
    logic [cgv_pkg::LETTER_W-1:0] expected_letters[$];
    int                           mismatches = 0;
    int                           msg_left   = 0;

    t_idle_mode idle_mode     = IDLE_NONE;
    bit         send_hold     = 1'b0;
    bit         long_hold_req = 1'b0;
    int         hold_count    = 0;
    int         quiet_cycles  = 0;

    // cipher state as seen by the checker
    logic [4:0]                   cfg_len     = 5'd1;
    logic                         cfg_decrypt = 1'b0;
    logic [cgv_pkg::LETTER_W-1:0] key_mem    [cgv_pkg::KEY_MAX];
    logic [cgv_pkg::LETTER_W-1:0] plain_ring [cgv_pkg::KEY_MAX];
    logic [cgv_pkg::LETTER_W-1:0] last_gamma  = '0;
    int                           ring_pos    = 0;
    bit                           wrapped     = 1'b0;

    function automatic int eff_len(input logic [4:0] v);
        int n;
        n = v;
        if (n == 0)
            n = 1;
        if (n > cgv_pkg::KEY_MAX)
            n = cgv_pkg::KEY_MAX;
        return n;
    endfunction

    task automatic apply_beat(input cgv_pkg::t_item beat);
        int lt, gamma, res, nxt;
        lt = (beat.letter >= 26) ? int'(beat.letter) - 26 : int'(beat.letter);
        if (beat.kind == cgv_pkg::KIND_KEY) begin
            key_mem[beat.key_slot] = cgv_pkg::LETTER_W'(lt);
        end else begin
            if (beat.restart) begin
                ring_pos   = 0;
                wrapped    = 1'b0;
                last_gamma = '0;
            end
            if (wrapped)
                gamma = (int'(plain_ring[ring_pos]) + int'(last_gamma)) % 26;
            else
                gamma = key_mem[ring_pos];
            if (cfg_decrypt) begin
                res = (lt + 26 - gamma) % 26;
                plain_ring[ring_pos] = cgv_pkg::LETTER_W'(res);
            end else begin
                res = (lt + gamma) % 26;
                plain_ring[ring_pos] = cgv_pkg::LETTER_W'(lt);
            end
            last_gamma = cgv_pkg::LETTER_W'(gamma);
            nxt = ring_pos + 1;
            if (nxt >= eff_len(cfg_len)) begin
                nxt     = 0;
                wrapped = 1'b1;
            end
            ring_pos = nxt;
            expected_letters.push_back(cgv_pkg::LETTER_W'(res));
        end
    endtask

    // input side: offers queued beats, holds payload while stalled
    always @(posedge i_clk) begin : letter_source
        int             pct;
        cgv_pkg::t_item head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid)
                void'(beat_queue.pop_front());
            pct = (idle_mode == IDLE_SEND) ? 64 : (idle_mode == IDLE_BOTH) ? 25 : 0;
            if (beat_queue.size() != 0 && !send_hold && $urandom_range(99) >= pct) begin
                head        = beat_queue[0];
                i_valid    <= 1'b1;
                i_kind     <= head.kind;
                i_letter   <= head.letter;
                i_key_slot <= head.key_slot;
                i_restart  <= head.restart;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side: checks results first, then predicts from the accepted input beat
    always @(posedge i_clk) begin : letter_sink
        logic [cgv_pkg::LETTER_W-1:0] want;
        cgv_pkg::t_item               beat;
        int                           pct;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_letters.size() == 0) begin
                    mismatches++;
                    $error("letter_out: no beat expected, got %0d", o_letter_out);
                end else begin
                    want = expected_letters.pop_front();
                    if (o_letter_out !== want) begin
                        mismatches++;
                        $error("letter_out: expected %0d, got %0d", want, o_letter_out);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                beat.kind     = i_kind;
                beat.letter   = i_letter;
                beat.key_slot = i_key_slot;
                beat.restart  = i_restart;
                apply_beat(beat);
            end
            pct = (idle_mode == IDLE_RECV) ? 64 : (idle_mode == IDLE_BOTH) ? 25 : 0;
            if (long_hold_req && hold_count < LONG_HOLD_CYCLES) begin
                hold_count <= hold_count + 1;
                i_stall    <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input cgv_pkg::t_reg_idx idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cgv_pkg::APB_AW'(4 * int'(idx));
        pwdata  <= cgv_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == cgv_pkg::REG_KEY_LENGTH)
            cfg_len = value[4:0];
        else
            cfg_decrypt = value[0];
    endtask

    function automatic cgv_pkg::t_item make_beat(input logic kind, input int letter,
                                                 input int slot, input bit restart);
        cgv_pkg::t_item b;
        b.kind     = kind;
        b.letter   = cgv_pkg::LETTER_W'(letter);
        b.key_slot = cgv_pkg::SLOT_W'(slot);
        b.restart  = restart;
        return b;
    endfunction

    // wait until every queued beat is in and every result is out
    task automatic drain();
        @(negedge i_clk);
        while (beat_queue.size() != 0 || i_valid || expected_letters.size() != 0)
            @(negedge i_clk);
        // a trailing key beat leaves no result behind it
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // messages open with restart; a few key reloads and stray restarts as noise
    task automatic queue_random(input int count, input bit restart_first);
        cgv_pkg::t_item b;
        for (int k = 0; k < count; k++) begin
            b.key_slot = cgv_pkg::SLOT_W'($urandom_range(15));
            if ($urandom_range(99) < 10) begin
                b.kind    = cgv_pkg::KIND_KEY;
                b.letter  = cgv_pkg::LETTER_W'($urandom_range(31));
                b.restart = 1'($urandom_range(1));
            end else begin
                b.kind   = cgv_pkg::KIND_TEXT;
                b.letter = ($urandom_range(99) < 90)
                         ? cgv_pkg::LETTER_W'($urandom_range(25))
                         : cgv_pkg::LETTER_W'($urandom_range(31, 26));
                if (msg_left == 0 || restart_first || $urandom_range(99) < 3) begin
                    b.restart     = 1'b1;
                    msg_left      = $urandom_range(40, 1);
                    restart_first = 1'b0;
                end else begin
                    b.restart = 1'b0;
                end
                msg_left--;
            end
            beat_queue.push_back(b);
        end
    endtask

    task automatic run_phase(input int len, input bit decrypt, input t_idle_mode mode,
                             input bit long_hold, input bit sender_pause);
        int prev_len;
        prev_len = eff_len(cfg_len);
        drain();
        write_reg(cgv_pkg::REG_KEY_LENGTH, len);
        write_reg(cgv_pkg::REG_DECRYPT_MODE, decrypt);
        @(negedge i_clk);
        idle_mode     = mode;
        long_hold_req = long_hold;
        // a longer key mid-message would read history that was never written
        queue_random(PHASE_BEATS, eff_len(5'(len)) > prev_len);
        if (sender_pause) begin
            while (beat_queue.size() > PHASE_BEATS / 2)
                @(negedge i_clk);
            send_hold = 1'b1;
            while (i_valid || expected_letters.size() != 0)
                @(negedge i_clk);
            send_hold = 1'b0;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill every key slot; some letters above z, some with a stray restart
        for (int s = 0; s < cgv_pkg::KEY_MAX; s++)
            beat_queue.push_back(make_beat(cgv_pkg::KIND_KEY, (s * 7 + 3) % 32, s, s[0]));
        // text straight out of reset, no restart, key length 1
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 0, 0, 1'b0));
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 31, 15, 1'b0));
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 25, 0, 1'b0));
        drain();
        write_reg(cgv_pkg::REG_KEY_LENGTH, cgv_pkg::KEY_MAX);
        write_reg(cgv_pkg::REG_DECRYPT_MODE, 0);
        @(negedge i_clk);
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 25, 0, 1'b1));
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 0, 0, 1'b0));
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 26, 0, 1'b0));
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 13, 0, 1'b0));
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 7, 0, 1'b1));
        beat_queue.push_back(make_beat(cgv_pkg::KIND_TEXT, 19, 0, 1'b0));

        run_phase(16, 1'b0, IDLE_NONE, 1'b0, 1'b0);
        run_phase(16, 1'b1, IDLE_SEND, 1'b0, 1'b0);
        run_phase(5,  1'b1, IDLE_RECV, 1'b0, 1'b0);
        run_phase(1,  1'b0, IDLE_BOTH, 1'b0, 1'b0);
        run_phase(0,  1'b1, IDLE_NONE, 1'b1, 1'b0);
        run_phase(31, 1'b0, IDLE_SEND, 1'b0, 1'b1);
        run_phase(3,  1'b1, IDLE_RECV, 1'b0, 1'b0);
        run_phase(16, 1'b0, IDLE_BOTH, 1'b0, 1'b0);
        run_phase(9,  1'b1, IDLE_NONE, 1'b0, 1'b0);
        run_phase(2,  1'b0, IDLE_SEND, 1'b0, 1'b0);
        run_phase(12, 1'b1, IDLE_RECV, 1'b0, 1'b0);
        run_phase(7,  1'b0, IDLE_BOTH, 1'b0, 1'b0);

        drain();
        if (mismatches == 0 && expected_letters.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
